FILE: rtl/ddc_pkg.sv
// ----------------------------------------------------------------------------
// Disk drive controller package
// Shared constants, command codes and types for the disk drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ddc_pkg;

  localparam int SIDE_BYTES   = 65536;
  localparam int IMAGE_DEPTH  = 131072;
  localparam int IMAGE_AW     = $clog2(IMAGE_DEPTH);

  localparam logic [7:0] XFER_CYCLES   = 8'd145;
  localparam logic [8:0] READY_SWITCH  = 9'd60;
  localparam logic [8:0] READY_POWERUP = 9'd420;

  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_FRAME = 3'd3,
    CMD_LOAD  = 3'd4
  } cmd_t;

  localparam logic [4:0] REG_RELOAD_LO = 5'h00;
  localparam logic [4:0] REG_RELOAD_HI = 5'h01;
  localparam logic [4:0] REG_IRQ_CTRL  = 5'h02;
  localparam logic [4:0] REG_WDATA     = 5'h04;
  localparam logic [4:0] REG_DRIVE     = 5'h05;
  localparam logic [4:0] REG_STATUS    = 5'h10;
  localparam logic [4:0] REG_RDATA     = 5'h11;
  localparam logic [4:0] REG_DRIVE_ST  = 5'h12;
  localparam logic [4:0] REG_BATTERY   = 5'h13;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
    logic       transfer_irq_pulse;
    logic       mirror_horizontal;
  } result_t;

  typedef struct packed {
    logic                re;
    logic                we;
    logic [IMAGE_AW-1:0] addr;
    logic [7:0]          wdata;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: rtl/ddc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, synchronous write, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     re,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ddc_ctrl.sv
// ----------------------------------------------------------------------------
// Disk drive controller command logic
// Executes one command a cycle against the timer, drive and image state.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [2:0]                in_cmd,
  input  wire logic [4:0]                in_offset,
  input  wire logic [7:0]                in_wdata,
  input  wire logic                      in_switch,
  input  wire logic [ddc_pkg::IMAGE_AW-1:0] in_addr,
  input  wire logic                      has_side_b,
  input  wire logic [7:0]                ram_rdata,
  output ddc_pkg::ram_req_t              ram_req,
  output ddc_pkg::result_t               res
);
  import ddc_pkg::*;

  logic [15:0] irq_reload, irq_reload_next;
  logic [15:0] irq_count, irq_count_next;
  logic        irq_enabled, irq_enabled_next;
  logic        timer_irq_flag, timer_irq_flag_next;
  logic        media_ready, media_ready_next;
  logic [8:0]  ready_count, ready_count_next;
  logic        xfer_done, xfer_done_next;
  logic        read_mode, read_mode_next;
  logic        crc_phase, crc_phase_next;
  logic        at_disk_start, at_disk_start_next;
  logic        motor_active, motor_active_next;
  logic [7:0]  transfer_byte, transfer_byte_next;
  logic        byte_pending, byte_pending_next;
  logic [1:0]  mode_switch_delay, mode_switch_delay_next;
  logic [7:0]  transfer_count, transfer_count_next;
  logic [15:0] disk_pos, disk_pos_next;
  logic        on_side_b, on_side_b_next;
  logic        mirroring, mirroring_next;

  logic [7:0]  byte_cur;
  logic [IMAGE_AW-1:0] pos_index;

  // The byte fetched from the image lands in the cycle after the read.
  assign byte_cur = byte_pending ? ram_rdata : transfer_byte;

  always_comb begin
    logic [IMAGE_AW-1:0] base;
    cmd_t                cmd;
    irq_reload_next        = irq_reload;
    irq_count_next         = irq_count;
    irq_enabled_next       = irq_enabled;
    timer_irq_flag_next    = timer_irq_flag;
    media_ready_next       = media_ready;
    ready_count_next       = ready_count;
    xfer_done_next         = xfer_done;
    read_mode_next         = read_mode;
    crc_phase_next         = crc_phase;
    at_disk_start_next     = at_disk_start;
    motor_active_next      = motor_active;
    transfer_byte_next     = byte_cur;
    byte_pending_next      = 1'b0;
    mode_switch_delay_next = mode_switch_delay;
    transfer_count_next    = transfer_count;
    disk_pos_next          = disk_pos;
    on_side_b_next         = on_side_b;
    mirroring_next         = mirroring;
    ram_req                = '0;
    res                    = '0;
    base                   = '0;
    cmd                    = cmd_t'(in_cmd);
    pos_index              = '0;

    if (in_valid) begin
      unique case (cmd)
        CMD_READ: begin
          unique case (in_offset)
            REG_STATUS: begin
              res.read_data = {1'b1, ~motor_active, 4'b0, xfer_done, timer_irq_flag};
              xfer_done_next      = 1'b0;
              timer_irq_flag_next = 1'b0;
            end
            REG_RDATA:    res.read_data = byte_cur;
            REG_DRIVE_ST: res.read_data = {6'b010000, ~motor_active, ~media_ready};
            REG_BATTERY:  res.read_data = 8'h80;
            default:      res.read_data = 8'h00;
          endcase
        end
        CMD_WRITE: begin
          unique case (in_offset)
            REG_RELOAD_LO: irq_reload_next[7:0]  = in_wdata;
            REG_RELOAD_HI: irq_reload_next[15:8] = in_wdata;
            REG_IRQ_CTRL: begin
              irq_enabled_next = in_wdata[1];
              irq_count_next   = in_wdata[1] ? irq_reload : 16'd0;
            end
            REG_WDATA: begin
              xfer_done_next = 1'b0;
              if (!read_mode) begin
                transfer_byte_next = in_wdata;
              end
            end
            REG_DRIVE: begin
              if (in_wdata[1]) begin
                disk_pos_next       = '0;
                at_disk_start_next  = 1'b1;
                crc_phase_next      = 1'b0;
                motor_active_next   = 1'b0;
                transfer_count_next = '0;
              end else begin
                motor_active_next = 1'b1;
                if (!in_wdata[2]) begin
                  if (read_mode) begin
                    read_mode_next         = 1'b0;
                    mode_switch_delay_next = 2'd2;
                  end
                end else begin
                  read_mode_next = 1'b1;
                end
                if (in_wdata[6]) begin
                  if (transfer_count == 8'd0) begin
                    transfer_count_next = XFER_CYCLES;
                  end
                end else begin
                  transfer_count_next = '0;
                end
              end
              mirroring_next = in_wdata[3];
              if (in_wdata[4] && !read_mode_next) begin
                if (!crc_phase_next) begin
                  disk_pos_next = disk_pos_next + 16'd2;
                end
                crc_phase_next = 1'b1;
              end else begin
                if (crc_phase_next) begin
                  byte_pending_next = 1'b1;
                  ram_req.re        = 1'b1;
                end
                crc_phase_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
        CMD_TICK: begin
          if (irq_count == 16'd1) begin
            if (irq_enabled) begin
              timer_irq_flag_next = 1'b1;
            end
            irq_count_next = '0;
          end else if (irq_count > 16'd1) begin
            irq_count_next = irq_count - 16'd1;
          end
          if (motor_active && !crc_phase) begin
            if (transfer_count == 8'd1) begin
              if (mode_switch_delay == 2'd0) begin
                if (!at_disk_start) begin
                  disk_pos_next = disk_pos + 16'd1;
                end
                if (read_mode) begin
                  byte_pending_next = 1'b1;
                  ram_req.re        = 1'b1;
                end else begin
                  ram_req.we    = 1'b1;
                  ram_req.wdata = byte_cur;
                end
              end else begin
                mode_switch_delay_next = mode_switch_delay - 2'd1;
              end
              xfer_done_next         = 1'b1;
              transfer_count_next    = XFER_CYCLES;
              res.transfer_irq_pulse = 1'b1;
              at_disk_start_next     = 1'b0;
            end else if (transfer_count > 8'd1) begin
              transfer_count_next = transfer_count - 8'd1;
            end
          end
        end
        CMD_FRAME: begin
          if (ready_count == 9'd1) begin
            media_ready_next = 1'b1;
            ready_count_next = '0;
          end else if (ready_count > 9'd1) begin
            ready_count_next = ready_count - 9'd1;
          end
          if (in_switch && has_side_b) begin
            on_side_b_next   = ~on_side_b;
            media_ready_next = 1'b0;
            ready_count_next = READY_SWITCH;
          end
        end
        CMD_LOAD: begin
          ram_req.we    = 1'b1;
          ram_req.wdata = in_wdata;
        end
        default: ;
      endcase
    end

    base      = on_side_b ? IMAGE_AW'(SIDE_BYTES) : '0;
    pos_index = base + IMAGE_AW'(32'(disk_pos_next) % SIDE_BYTES);
    ram_req.addr = (in_valid && cmd == CMD_LOAD) ? in_addr : pos_index;

    res.timer_irq         = timer_irq_flag_next;
    res.mirror_horizontal = mirroring_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_reload        <= '0;
      irq_count         <= '0;
      irq_enabled       <= 1'b0;
      timer_irq_flag    <= 1'b0;
      media_ready       <= 1'b0;
      ready_count       <= READY_POWERUP;
      xfer_done         <= 1'b0;
      read_mode         <= 1'b1;
      crc_phase         <= 1'b0;
      at_disk_start     <= 1'b1;
      motor_active      <= 1'b0;
      transfer_byte     <= '0;
      byte_pending      <= 1'b0;
      mode_switch_delay <= '0;
      transfer_count    <= '0;
      disk_pos          <= '0;
      on_side_b         <= 1'b0;
      mirroring         <= 1'b0;
    end else begin
      irq_reload        <= irq_reload_next;
      irq_count         <= irq_count_next;
      irq_enabled       <= irq_enabled_next;
      timer_irq_flag    <= timer_irq_flag_next;
      media_ready       <= media_ready_next;
      ready_count       <= ready_count_next;
      xfer_done         <= xfer_done_next;
      read_mode         <= read_mode_next;
      crc_phase         <= crc_phase_next;
      at_disk_start     <= at_disk_start_next;
      motor_active      <= motor_active_next;
      transfer_byte     <= transfer_byte_next;
      byte_pending      <= byte_pending_next;
      mode_switch_delay <= mode_switch_delay_next;
      transfer_count    <= transfer_count_next;
      disk_pos          <= disk_pos_next;
      on_side_b         <= on_side_b_next;
      mirroring         <= mirroring_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ddc_skid.sv
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with a skid stage so the input side waits on a stall only once the skid stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire ddc_pkg::result_t in_res,
  output logic                  in_ready,
  output logic                  out_valid,
  output ddc_pkg::result_t      out_res,
  input  wire logic             out_ready
);
  import ddc_pkg::*;

  result_t skid_res;
  logic    skid_valid;

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        out_res   <= in_res;
      end
    end else if (in_valid) begin
      skid_res   <= in_res;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/disk_drive_controller_core.sv
// ----------------------------------------------------------------------------
// Disk drive controller core
// Timer, transfer, drive state and two-sided image store of a disk adapter.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word, registered in the output buffer.
// A word can be accepted every cycle while the output buffer has room; the image memory is accessed at most
// once per word, and a fetched byte is forwarded to the next word.
// A two-entry output buffer takes one more word after the output stalls.
// Reset is synchronous; the image store is not cleared and must be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_drive_controller_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,       // has_side_b
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // reg_offset[4:0], write_data[12:5], switch_side[13], image_addr[30:14]
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic [2:0]  s_axis_tuser,   // cmd[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[7:0], timer_irq[8], transfer_irq_pulse[9], mirror_horizontal[10]
  output logic [15:0]      m_axis_tdata
);
  import ddc_pkg::*;

  logic     has_side_b;
  logic     accept;
  logic [7:0] ram_rdata;
  ram_req_t ram_req;
  result_t  res;
  result_t  out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_side_b <= 1'b0;
    end else if (cfg_we) begin
      has_side_b <= cfg_data;
    end
  end

  assign accept = s_axis_tvalid & s_axis_tready;

  ddc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_cmd    (s_axis_tuser),
    .in_offset (s_axis_tdata[4:0]),
    .in_wdata  (s_axis_tdata[12:5]),
    .in_switch (s_axis_tdata[13]),
    .in_addr   (s_axis_tdata[14 +: IMAGE_AW]),
    .has_side_b(has_side_b),
    .ram_rdata (ram_rdata),
    .ram_req   (ram_req),
    .res       (res)
  );

  ddc_ram #(
    .WIDTH(8),
    .DEPTH(IMAGE_DEPTH)
  ) u_image (
    .clk  (clk),
    .re   (ram_req.re),
    .we   (ram_req.we),
    .addr (ram_req.addr),
    .wdata(ram_req.wdata),
    .rdata(ram_rdata)
  );

  ddc_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_res   (res),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_res  (out_res),
    .out_ready(m_axis_tready)
  );

  assign m_axis_tdata = {5'b0, out_res.mirror_horizontal, out_res.transfer_irq_pulse,
                         out_res.timer_irq, out_res.read_data};

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Disk drive controller core testbench
// Drives register, tick, frame and image-load words into the core while both
// stream sides idle at random, predicts every result word from a behavioral
// model of the drive kept here, and compares each field of every result word
// in arrival order. Image reads are steered so that only loaded bytes are read.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ddc_pkg::*;

  localparam logic [4:0] REG_NONE       = 5'h1F;
  localparam logic [2:0] CMD_LAST       = 3'd7;
  localparam logic [7:0] IRQ_EN         = 8'h02;
  localparam logic [7:0] DRV_POS_RESET  = 8'h02;
  localparam logic [7:0] DRV_READ       = 8'h04;
  localparam logic [7:0] DRV_MIRROR_H   = 8'h08;
  localparam logic [7:0] DRV_CRC        = 8'h10;
  localparam logic [7:0] DRV_XFER_EN    = 8'h40;
  localparam logic [7:0] STATUS_FIXED   = 8'h80;
  localparam logic [7:0] DRIVE_ST_FIXED = 8'h40;
  localparam logic [7:0] BATTERY_OK     = 8'h80;
  localparam logic [1:0] SWITCH_XFERS   = 2'd2;
  localparam int         PRELOAD_BYTES  = 32;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  off;
    logic [7:0]  data;
    logic        flip;
    logic [16:0] addr;
  } disk_cmd_t;

  typedef struct packed {
    logic [15:0] irq_reload;
    logic [15:0] irq_count;
    logic        irq_en;
    logic        irq_flag;
    logic        ready;
    logic [8:0]  ready_cnt;
    logic        xfer_done;
    logic        rd_mode;
    logic        crc;
    logic        at_start;
    logic        motor;
    logic [7:0]  xfer_byte;
    logic [1:0]  sw_delay;
    logic [7:0]  xfer_cnt;
    logic [15:0] pos;
    logic        side_b;
    logic        mirror;
  } drive_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = CMD_READ;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  drive_t     drive_now;
  logic       side_b_present = 1'b0;
  logic [7:0] image_bytes [IMAGE_DEPTH];
  bit         image_known [IMAGE_DEPTH];
  result_t    awaited_results [$];
  int         src_idle_pct = 0;
  int         sink_idle_pct = 0;
  int         hold_cycles = 0;
  int         err_count = 0;

  disk_drive_controller_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [16:0] image_slot(input drive_t s);
    return 17'((s.side_b ? SIDE_BYTES : 0) + (int'(s.pos) % SIDE_BYTES));
  endfunction

  function automatic logic [7:0] fetch_byte(input drive_t s, inout bit miss);
    logic [16:0] idx;
    idx = image_slot(s);
    if (!image_known[idx]) miss = 1'b1;
    return image_bytes[idx];
  endfunction

  function automatic result_t advance_drive(inout drive_t s, input disk_cmd_t c,
                                            input bit commit, output bit miss);
    result_t     r;
    logic [7:0]  v;
    logic [16:0] idx;
    r = '0;
    miss = 1'b0;
    v = c.data;
    case (c.cmd)
      CMD_READ: begin
        case (c.off)
          REG_STATUS: begin
            r.read_data = STATUS_FIXED | {1'b0, ~s.motor, 4'b0, s.xfer_done, s.irq_flag};
            s.xfer_done = 1'b0;
            s.irq_flag = 1'b0;
          end
          REG_RDATA:    r.read_data = s.xfer_byte;
          REG_DRIVE_ST: r.read_data = DRIVE_ST_FIXED | {6'b0, ~s.motor, ~s.ready};
          REG_BATTERY:  r.read_data = BATTERY_OK;
          default: ;
        endcase
      end
      CMD_WRITE: begin
        case (c.off)
          REG_RELOAD_LO: s.irq_reload[7:0] = v;
          REG_RELOAD_HI: s.irq_reload[15:8] = v;
          REG_IRQ_CTRL: begin
            s.irq_en = v[1];
            s.irq_count = v[1] ? s.irq_reload : 16'd0;
          end
          REG_WDATA: begin
            s.xfer_done = 1'b0;
            if (!s.rd_mode) s.xfer_byte = v;
          end
          REG_DRIVE: begin
            if ((v & DRV_POS_RESET) != 0) begin
              s.pos = '0;
              s.at_start = 1'b1;
              s.crc = 1'b0;
              s.motor = 1'b0;
              s.xfer_cnt = '0;
            end else begin
              s.motor = 1'b1;
              if ((v & DRV_READ) == 0) begin
                if (s.rd_mode) begin
                  s.rd_mode = 1'b0;
                  s.sw_delay = SWITCH_XFERS;
                end
              end else begin
                s.rd_mode = 1'b1;
              end
              if ((v & DRV_XFER_EN) != 0) begin
                if (s.xfer_cnt == 0) s.xfer_cnt = XFER_CYCLES;
              end else begin
                s.xfer_cnt = '0;
              end
            end
            s.mirror = (v & DRV_MIRROR_H) != 0;
            if ((v & DRV_CRC) != 0 && !s.rd_mode) begin
              if (!s.crc) s.pos = s.pos + 16'd2;
              s.crc = 1'b1;
            end else begin
              if (s.crc) s.xfer_byte = fetch_byte(s, miss);
              s.crc = 1'b0;
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (s.irq_count == 1) begin
          if (s.irq_en) s.irq_flag = 1'b1;
          s.irq_count = '0;
        end else if (s.irq_count > 1) begin
          s.irq_count = s.irq_count - 16'd1;
        end
        if (s.motor && !s.crc) begin
          if (s.xfer_cnt == 1) begin
            if (s.sw_delay == 0) begin
              if (!s.at_start) s.pos = s.pos + 16'd1;
              if (s.rd_mode) begin
                s.xfer_byte = fetch_byte(s, miss);
              end else if (commit) begin
                idx = image_slot(s);
                image_bytes[idx] = s.xfer_byte;
                image_known[idx] = 1'b1;
              end
            end else begin
              s.sw_delay = s.sw_delay - 2'd1;
            end
            s.xfer_done = 1'b1;
            s.xfer_cnt = XFER_CYCLES;
            r.transfer_irq_pulse = 1'b1;
            s.at_start = 1'b0;
          end else if (s.xfer_cnt > 1) begin
            s.xfer_cnt = s.xfer_cnt - 8'd1;
          end
        end
      end
      CMD_FRAME: begin
        if (s.ready_cnt == 1) begin
          s.ready = 1'b1;
          s.ready_cnt = '0;
        end else if (s.ready_cnt > 1) begin
          s.ready_cnt = s.ready_cnt - 9'd1;
        end
        if (c.flip && side_b_present) begin
          s.side_b = ~s.side_b;
          s.ready = 1'b0;
          s.ready_cnt = READY_SWITCH;
        end
      end
      CMD_LOAD: begin
        if (commit) begin
          image_bytes[c.addr] = v;
          image_known[c.addr] = 1'b1;
        end
      end
      default: ;
    endcase
    r.timer_irq = s.irq_flag;
    r.mirror_horizontal = s.mirror;
    return r;
  endfunction

  function automatic disk_cmd_t make_word(input logic [2:0] cmd, input logic [4:0] off,
                                          input logic [7:0] data, input logic flip,
                                          input logic [16:0] addr);
    disk_cmd_t c;
    c.cmd = cmd;
    c.off = off;
    c.data = data;
    c.flip = flip;
    c.addr = addr;
    return c;
  endfunction

  function automatic disk_cmd_t random_word();
    return make_word(3'($urandom_range(7)), 5'($urandom), 8'($urandom), 1'($urandom),
                     17'($urandom));
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t ns: %s got %h want %h", $time, what, got, want);
    err_count++;
  endtask

  // Any word that would read an image byte never loaded is replaced by a head reset.
  task automatic send_word(input disk_cmd_t c);
    drive_t  trial;
    result_t r;
    bit      miss;
    int      gap;
    trial = drive_now;
    r = advance_drive(trial, c, 1'b0, miss);
    if (miss)
      c = make_word(CMD_WRITE, REG_DRIVE,
                    DRV_POS_RESET | ($urandom_range(1) ? DRV_MIRROR_H : 8'h00), 1'b0, '0);
    gap = 0;
    while (gap < 30 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, c.addr, c.flip, c.data, c.off};
    s_axis_tuser <= c.cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = advance_drive(drive_now, c, 1'b1, miss);
    awaited_results.push_back(r);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_side_b(input logic value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    side_b_present = value;
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  task automatic load_image();
    for (int i = 0; i < PRELOAD_BYTES; i++) begin
      send_word(make_word(CMD_LOAD, 5'($urandom), 8'($urandom), 1'b0, 17'(i)));
      send_word(make_word(CMD_LOAD, 5'($urandom), 8'($urandom), 1'b0, 17'(SIDE_BYTES + i)));
    end
  endtask

  task automatic directed_checks();
    send_word(make_word(CMD_READ, REG_BATTERY, '0, 1'b0, '0));
    send_word(make_word(CMD_READ, REG_DRIVE_ST, '0, 1'b0, '0));
    send_word(make_word(CMD_READ, REG_STATUS, '0, 1'b0, '0));
    send_word(make_word(CMD_READ, REG_RDATA, '0, 1'b0, '0));
    send_word(make_word(CMD_READ, REG_NONE, '1, 1'b1, '1));
    send_word(make_word(CMD_WRITE, REG_NONE, '1, 1'b1, '1));
    send_word(make_word(CMD_WRITE, REG_RELOAD_LO, 8'hFF, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_RELOAD_HI, 8'hFF, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_IRQ_CTRL, IRQ_EN, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_IRQ_CTRL, 8'h00, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_RELOAD_LO, 8'h02, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_RELOAD_HI, 8'h00, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_IRQ_CTRL, IRQ_EN, 1'b0, '0));
    send_word(make_word(CMD_TICK, '0, '0, 1'b0, '0));
    send_word(make_word(CMD_TICK, '0, '0, 1'b0, '0));
    send_word(make_word(CMD_READ, REG_STATUS, '0, 1'b0, '0));
    for (int c = CMD_LOAD + 1; c <= CMD_LAST; c++)
      send_word(make_word(3'(c), '1, '1, 1'b1, '1));
    send_word(make_word(CMD_LOAD, '0, 8'hFF, 1'b0, '1));
    send_word(make_word(CMD_LOAD, '0, 8'h00, 1'b0, '0));
    send_word(make_word(CMD_FRAME, '0, '0, 1'b1, '0));
    send_word(make_word(CMD_WRITE, REG_DRIVE, 8'hFF, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_DRIVE, 8'h00, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_WDATA, 8'hFF, 1'b0, '0));
    send_word(make_word(CMD_READ, REG_RDATA, '0, 1'b0, '0));
  endtask

  task automatic frames_until_ready();
    disk_cmd_t c;
    while (!drive_now.ready) begin
      c = random_word();
      if ($urandom_range(7) == 0) begin
        c.cmd = CMD_READ;
        c.off = REG_DRIVE_ST;
      end else begin
        c.cmd = CMD_FRAME;
        c.flip = side_b_present ? 1'b0 : c.flip;
      end
      send_word(c);
    end
  endtask

  task automatic power_up_ready();
    frames_until_ready();
    send_word(make_word(CMD_READ, REG_DRIVE_ST, '0, 1'b0, '0));
  endtask

  task automatic side_switch();
    send_word(make_word(CMD_FRAME, '0, '0, 1'b1, '0));
    frames_until_ready();
    send_word(make_word(CMD_READ, REG_DRIVE_ST, '0, 1'b0, '0));
  endtask

  task automatic drive_session(input int n_items);
    disk_cmd_t  c;
    logic [7:0] ctl;
    int         pick;
    ctl = DRV_XFER_EN | ($urandom_range(1) ? DRV_READ : 8'h00)
        | ($urandom_range(1) ? DRV_MIRROR_H : 8'h00);
    send_word(make_word(CMD_WRITE, REG_RELOAD_LO, 8'($urandom), 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_RELOAD_HI, 8'($urandom_range(1)), 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_IRQ_CTRL,
                        $urandom_range(3) != 0 ? IRQ_EN : 8'h00, 1'b0, '0));
    send_word(make_word(CMD_WRITE, REG_DRIVE, ctl, 1'b0, '0));
    repeat (n_items) begin
      c = random_word();
      pick = $urandom_range(99);
      if (pick < 68) begin
        c.cmd = CMD_TICK;
      end else if (pick < 76) begin
        c.cmd = CMD_READ;
        c.off = REG_STATUS + 5'($urandom_range(3));
      end else if (pick < 82) begin
        c.cmd = CMD_WRITE;
        c.off = REG_WDATA;
      end else if (pick < 87) begin
        ctl = ctl ^ (8'($urandom) & (DRV_READ | DRV_MIRROR_H | DRV_CRC));
        c.cmd = CMD_WRITE;
        c.off = REG_DRIVE;
        c.data = ctl;
      end else if (pick < 91) begin
        c.cmd = CMD_WRITE;
        case ($urandom_range(2))
          0: c.off = REG_RELOAD_LO;
          1: begin
            c.off = REG_RELOAD_HI;
            if ($urandom_range(3) != 0) c.data = 8'($urandom_range(1));
          end
          default: c.off = REG_IRQ_CTRL;
        endcase
      end else if (pick < 94) begin
        c.cmd = CMD_FRAME;
      end else if (pick < 96) begin
        c.cmd = CMD_LOAD;
      end
      send_word(c);
    end
  endtask

  task automatic fill_stall();
    disk_cmd_t c;
    hold_cycles = 40;
    repeat (30) begin
      c = random_word();
      c.cmd = $urandom_range(1) ? CMD_TICK : CMD_READ;
      send_word(c);
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("word with nothing awaited, read_data", m_axis_tdata[7:0], 8'h00);
      end else begin
        want = awaited_results.pop_front();
        if (m_axis_tdata[7:0] !== want.read_data)
          report_mismatch("read_data", m_axis_tdata[7:0], want.read_data);
        if (m_axis_tdata[8] !== want.timer_irq)
          report_mismatch("timer_irq", 8'(m_axis_tdata[8]), 8'(want.timer_irq));
        if (m_axis_tdata[9] !== want.transfer_irq_pulse)
          report_mismatch("transfer_irq_pulse", 8'(m_axis_tdata[9]),
                          8'(want.transfer_irq_pulse));
        if (m_axis_tdata[10] !== want.mirror_horizontal)
          report_mismatch("mirror_horizontal", 8'(m_axis_tdata[10]),
                          8'(want.mirror_horizontal));
      end
    end
  end

  initial begin
    drive_now = '0;
    drive_now.ready_cnt = READY_POWERUP;
    drive_now.rd_mode = 1'b1;
    drive_now.at_start = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_side_b(1'b0);
    set_idling(18, 63);
    load_image();
    directed_checks();
    power_up_ready();
    set_side_b(1'b1);
    side_switch();
    drive_session(300);
    set_idling(63, 18);
    drive_session(300);
    set_side_b(1'b0);
    drive_session(250);
    set_idling(0, 0);
    fill_stall();
    set_side_b(1'b1);
    drive_session(250);
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: disk_drive_controller_core.f
rtl/ddc_pkg.sv
rtl/ddc_ram.sv
rtl/ddc_ctrl.sv
rtl/ddc_skid.sv
rtl/disk_drive_controller_core.sv
bench/tb_top.sv
